@@ src/art_pkg.sv @@
// Package for the aging route table: sizes, codes and shared transaction types.
`default_nettype none
package art_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int STATION_BITS  = 16;
    localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [1:0] OP_LEARN  = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_PURGE  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef logic [STATION_BITS-1:0] station_t;
    typedef logic [IDX_BITS-1:0]     idx_t;

    // Request walking down the cell chain, with the results gathered so far.
    typedef struct packed {
        logic [1:0]  op;
        station_t    sid;
        station_t    via;
        logic [7:0]  hops;
        logic [31:0] expiry;
        logic [31:0] now;
        logic        found;
        station_t    next_hop;
        logic        free_hit;
        idx_t        free_idx;
    } art_pkt_t;

    // Broadcast insert into one cell at the end of a learn pass.
    typedef struct packed {
        logic        en;
        idx_t        idx;
        station_t    dst;
        station_t    via;
        logic [7:0]  len;
        logic [31:0] expiry;
    } art_ins_t;

    typedef struct packed {
        logic        found;
        logic [15:0] next_hop;
        logic [1:0]  status;
    } art_res_t;

endpackage
`default_nettype wire

@@ src/aging_route_table.sv @@
// Aging route table top level: request head, chain of entry cells, result queue.
//
//  channel | ports                      | dir | handshake
//  --------+----------------------------+-----+--------------------------
//  input   | s_operation .. s_current_time | in  | s_valid / s_ready
//  result  | m_found, m_next_hop, m_status | out | m_valid / m_ready
//  config  | cfg_wr_data (route_lifetime)  | in  | cfg_wr_en, no wait
//
//  A transaction loads into the head stage at the accepting edge, then moves
//  one entry cell per cycle through all TABLE_ENTRIES cells and then enters
//  the result queue. One request is in the chain at a time, so a new request
//  is not accepted until the current one has left the chain.
//  A two-deep result queue lets the next request enter while one result
//  waits; s_ready drops only when the chain is busy or two results wait.
//  Reset clears all entry valid bits at once, no clearing pass is needed.
`default_nettype none
module aging_route_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [15:0] s_station_id,
    input  wire logic [15:0] s_via_station,
    input  wire logic [7:0]  s_hop_count,
    input  wire logic [31:0] s_current_time,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic [15:0]      m_next_hop,
    output logic [1:0]       m_status
);
    import art_pkg::*;

    logic [15:0] lifetime_reg;
    logic        busy_reg;
    logic        head_valid_reg;
    art_pkt_t    head_pkt_reg, head_pkt_next;
    logic [32:0] expiry_sum;

    logic [TABLE_ENTRIES-1:0] chain_valid;
    art_pkt_t                 chain_pkt [TABLE_ENTRIES];
    art_pkt_t                 last_pkt;
    logic                     done;
    art_ins_t                 ins;
    art_res_t                 res;

    art_res_t    q0_reg, q1_reg;
    logic [1:0]  q_cnt_reg;
    logic        s_fire, m_fire;

    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign s_ready = !busy_reg && (q_cnt_reg != 2'd2);

    // Expiry saturates at the top of the time range.
    assign expiry_sum = {1'b0, s_current_time} + 33'(lifetime_reg);

    always_comb begin
        head_pkt_next          = '0;
        head_pkt_next.op       = s_operation;
        head_pkt_next.sid      = STATION_BITS'(s_station_id);
        head_pkt_next.via      = STATION_BITS'(s_via_station);
        head_pkt_next.hops     = s_hop_count;
        head_pkt_next.expiry   = expiry_sum[32] ? '1 : expiry_sum[31:0];
        head_pkt_next.now      = s_current_time;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lifetime_reg   <= 16'd1000;
            busy_reg       <= 1'b0;
            head_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                lifetime_reg <= cfg_wr_data;
            end
            head_valid_reg <= s_fire;
            if (s_fire) begin
                busy_reg <= 1'b1;
            end else if (done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            head_pkt_reg <= head_pkt_next;
        end
    end

    // Entry cells, request handed one cell further each cycle.
    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        if (i == 0) begin : g_first
            art_cell u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .cell_idx      (IDX_BITS'(i)),
                .in_valid      (head_valid_reg),
                .in_pkt        (head_pkt_reg),
                .ins           (ins),
                .out_valid_reg (chain_valid[i]),
                .out_pkt_reg   (chain_pkt[i])
            );
        end else begin : g_next
            art_cell u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .cell_idx      (IDX_BITS'(i)),
                .in_valid      (chain_valid[i-1]),
                .in_pkt        (chain_pkt[i-1]),
                .ins           (ins),
                .out_valid_reg (chain_valid[i]),
                .out_pkt_reg   (chain_pkt[i])
            );
        end
    end

    assign done     = chain_valid[TABLE_ENTRIES-1];
    assign last_pkt = chain_pkt[TABLE_ENTRIES-1];

    // New route goes into the lowest free slot seen on the way down.
    always_comb begin
        ins.en     = done && (last_pkt.op == OP_LEARN) && !last_pkt.found
                     && last_pkt.free_hit;
        ins.idx    = last_pkt.free_idx;
        ins.dst    = last_pkt.sid;
        ins.via    = last_pkt.via;
        ins.len    = last_pkt.hops;
        ins.expiry = last_pkt.expiry;
    end

    always_comb begin
        res          = '0;
        res.found    = last_pkt.found;
        res.status   = ST_OK;
        if (last_pkt.op == OP_LOOKUP) begin
            res.next_hop = 16'(last_pkt.next_hop);
            if (!last_pkt.found) begin
                res.status = ST_NOT_FOUND;
            end
        end else if (last_pkt.op == OP_LEARN) begin
            if (!last_pkt.found && !last_pkt.free_hit) begin
                res.status = ST_FULL;
            end
        end
    end

    // Two-deep result queue, q0 is the head.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cnt_reg <= 2'd0;
        end else begin
            q_cnt_reg <= q_cnt_reg + {1'b0, done} - {1'b0, m_fire};
        end
    end

    always_ff @(posedge aclk) begin
        priority if (m_fire && done) begin
            if (q_cnt_reg == 2'd1) begin
                q0_reg <= res;
            end else begin
                q0_reg <= q1_reg;
                q1_reg <= res;
            end
        end else if (m_fire) begin
            q0_reg <= q1_reg;
        end else if (done) begin
            if (q_cnt_reg == 2'd0) begin
                q0_reg <= res;
            end else begin
                q1_reg <= res;
            end
        end
    end

    assign m_valid    = (q_cnt_reg != 2'd0);
    assign m_found    = q0_reg.found;
    assign m_next_hop = q0_reg.next_hop;
    assign m_status   = q0_reg.status;

    // At most one request in flight anywhere in the chain.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({head_valid_reg, chain_valid}) <= 1)
        else $error("more than one request in the cell chain");

    // Accepting implies the chain is empty.
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> ({head_valid_reg, chain_valid} == '0))
        else $error("ready while chain busy");

    // The queue never overflows.
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (q_cnt_reg != 2'd2) || m_fire)
        else $error("result queue overflow");

    // A finished request frees the block for the next one.
    a_busy_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !busy_reg)
        else $error("busy not cleared after completion");

endmodule
`default_nettype wire

@@ src/art_cell.sv @@
// One route entry cell: holds an entry and processes the request passing by.
`default_nettype none
module art_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire art_pkg::idx_t     cell_idx,
    input  wire logic              in_valid,
    input  wire art_pkg::art_pkt_t in_pkt,
    input  wire art_pkg::art_ins_t ins,
    output logic                   out_valid_reg,
    output art_pkg::art_pkt_t      out_pkt_reg
);
    import art_pkg::*;

    logic        valid_reg, valid_next;
    station_t    dest_reg;
    station_t    transit_reg;
    logic [7:0]  len_reg;
    logic [31:0] expiry_reg;
    art_pkt_t    out_pkt_next;
    logic        match;
    logic        ins_hit;
    logic        refresh;

    assign match   = valid_reg && (dest_reg == in_pkt.sid);
    assign ins_hit = ins.en && (ins.idx == cell_idx);
    assign refresh = in_valid && (in_pkt.op == OP_LEARN) && match && !in_pkt.found
                     && (len_reg >= in_pkt.hops);

    always_comb begin
        out_pkt_next = in_pkt;
        valid_next   = valid_reg;
        if (in_valid) begin
            unique case (in_pkt.op)
                OP_LEARN: begin
                    if (match && !in_pkt.found) begin
                        out_pkt_next.found = 1'b1;
                    end
                    if (!valid_reg && !in_pkt.free_hit) begin
                        out_pkt_next.free_hit = 1'b1;
                        out_pkt_next.free_idx = cell_idx;
                    end
                end
                OP_LOOKUP: begin
                    if (match && !in_pkt.found) begin
                        out_pkt_next.found    = 1'b1;
                        out_pkt_next.next_hop = transit_reg;
                    end
                end
                OP_PURGE: begin
                    if (valid_reg && (expiry_reg <= in_pkt.now)) begin
                        valid_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
        if (ins_hit) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        out_pkt_reg <= out_pkt_next;
        if (ins_hit) begin
            dest_reg    <= ins.dst;
            transit_reg <= ins.via;
            len_reg     <= ins.len;
            expiry_reg  <= ins.expiry;
        end else if (refresh) begin
            transit_reg <= in_pkt.via;
            len_reg     <= in_pkt.hops;
            expiry_reg  <= in_pkt.expiry;
        end
    end

endmodule
`default_nettype wire
